@@ rtl/tccs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and constants of the text console cursor/scroll engine.
// ----------------------------------------------------------------------------
package tccs_pkg;

    // Cell store geometry
    localparam int unsigned CELLS   = 16384;
    localparam int unsigned CELL_AW = $clog2(CELLS);

    localparam logic [15:0] BLANK_CELL   = 16'h0F20;
    localparam logic [7:0]  TEXT_ATTR    = 8'h0F;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;

    // Register reset values
    localparam logic [7:0]  COLS_RST = 8'd80;
    localparam logic [6:0]  ROWS_RST = 7'd25;
    localparam logic [13:0] AREA_RST = 14'd2000;

    // Register clamps
    localparam logic [7:0]  COLS_MAX = 8'd128;
    localparam logic [6:0]  ROWS_MAX = 7'd64;

    // Command codes
    localparam logic [1:0] CMD_WRITE     = 2'd0;
    localparam logic [1:0] CMD_BACKSPACE = 2'd1;
    localparam logic [1:0] CMD_READ      = 2'd2;

    // Register indexes
    localparam int unsigned CFG_IDX_W   = 1;
    localparam logic [0:0]  CFG_COLUMNS = 1'b0;
    localparam logic [0:0]  CFG_ROWS    = 1'b1;
    localparam int unsigned CFG_DW      = 8;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  char_code;
        logic [13:0] read_address;
    } t_in_item;

    typedef struct packed {
        logic [13:0] cursor_out;
        logic [13:0] display_start;
        logic [15:0] cell_data;
        logic        applied;
    } t_out_item;

    typedef struct packed {
        logic               we;
        logic [CELL_AW-1:0] waddr;
        logic [15:0]        wdata;
        logic               re;
        logic [CELL_AW-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [7:0]  cols;
        logic [6:0]  rows;
        logic [13:0] area;
    } t_geom;

endpackage
`default_nettype wire

@@ rtl/tccs_cell_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_cell_ram
// Character cell store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tccs_cell_ram
    import tccs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_ram_req    i_req,
    output logic      [15:0] o_rdata
);

    logic [15:0] r_mem [CELLS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/tccs_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_seq
// Cursor/scroll sequencer: drives the cell store at most one write a cycle and
// holds the result register.
// ----------------------------------------------------------------------------
module tccs_seq
    import tccs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_geom       i_geom,
    input  wire logic        i_cfg_clr,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_item,
    output t_ram_req         o_ram_req,
    input  wire logic [15:0] i_ram_rdata
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_PLACE  = 9'b000000100,
        S_MIRROR = 9'b000001000,
        S_ROWCHK = 9'b000010000,
        S_ROWCLR = 9'b000100000,
        S_FOLLOW = 9'b001000000,
        S_READ   = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state              r_state,   n_state;
    logic [13:0]         r_cur,     n_cur;
    logic [6:0]          r_col,     n_col;
    logic [13:0]         r_start,   n_start;
    logic [CELL_AW-1:0]  r_addr,    n_addr;
    logic [7:0]          r_cnt,     n_cnt;
    logic [15:0]         r_cell,    n_cell;
    logic                r_newline, n_newline;
    logic                r_bs,      n_bs;
    logic                r_applied, n_applied;
    logic [15:0]         r_data,    n_data;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_item,  n_out_item;

    logic        in_acc;
    logic [14:0] area15;
    logic [14:0] cur15;
    logic [14:0] win_end;
    logic [14:0] wrap_pos;
    logic [14:0] start_nx;
    logic [7:0]  guard_lim;
    logic [6:0]  col_inc;
    logic [6:0]  col_dec;
    logic        last_col;
    logic        in_win;

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign area15    = {1'b0, i_geom.area};
    assign cur15     = {1'b0, r_cur};
    assign win_end   = {1'b0, r_start} + area15;
    assign wrap_pos  = (area15 << 1) - {7'b0, i_geom.cols};
    assign start_nx  = {1'b0, r_start} + {7'b0, i_geom.cols};
    assign guard_lim = {i_geom.rows, 1'b0} + 8'd2;
    assign last_col  = ({1'b0, r_col} == (i_geom.cols - 8'd1));
    assign col_inc   = last_col ? 7'd0 : (r_col + 7'd1);
    assign col_dec   = (r_col == 7'd0) ? 7'((i_geom.cols - 8'd1)) : (r_col - 7'd1);
    assign in_win    = (r_cur >= r_start) && (cur15 < win_end);

    // Store port
    always_comb begin
        o_ram_req       = '0;
        o_ram_req.waddr = r_cur;
        o_ram_req.wdata = r_cell;
        o_ram_req.raddr = i_in_item.read_address;
        case (r_state)
            S_CLEAR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_addr;
                o_ram_req.wdata = BLANK_CELL;
            end
            S_PLACE: begin
                o_ram_req.we = 1'b1;
            end
            S_MIRROR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_cur - i_geom.area;
            end
            S_ROWCLR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_addr;
                o_ram_req.wdata = BLANK_CELL;
            end
            S_IDLE: begin
                o_ram_req.re = in_acc && (i_in_item.command == CMD_READ);
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_col       = r_col;
        n_start     = r_start;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_cell      = r_cell;
        n_newline   = r_newline;
        n_bs        = r_bs;
        n_applied   = r_applied;
        n_data      = r_data;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_applied = 1'b0;
                    n_data    = 16'd0;
                    case (i_in_item.command)
                        CMD_WRITE: begin
                            n_newline = (i_in_item.char_code == NEWLINE_CODE);
                            n_cell    = n_newline ? BLANK_CELL
                                                  : {TEXT_ATTR, i_in_item.char_code};
                            n_bs      = 1'b0;
                            n_applied = 1'b1;
                            n_state   = S_PLACE;
                        end
                        CMD_BACKSPACE: begin
                            if (r_cur > r_start) begin
                                n_cur     = r_cur - 14'd1;
                                n_col     = col_dec;
                                n_cell    = BLANK_CELL;
                                n_bs      = 1'b1;
                                n_applied = 1'b1;
                                n_state   = S_PLACE;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        CMD_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_PLACE, S_MIRROR: begin
                if ((r_state == S_PLACE) && (r_cur >= i_geom.area)) begin
                    n_state = S_MIRROR;
                end else if (r_bs) begin
                    n_state = S_DONE;
                end else begin
                    n_cur = r_cur + 14'd1;
                    n_col = col_inc;
                    if (r_newline && (col_inc != 7'd0)) begin
                        n_state = S_PLACE;
                    end else begin
                        n_state = S_ROWCHK;
                    end
                end
            end
            S_ROWCHK: begin
                n_cnt = 8'd0;
                if (r_col == 7'd0) begin
                    n_addr  = r_cur;
                    n_state = S_ROWCLR;
                    // last row of the store: fall back one screen
                    if (cur15 == wrap_pos) begin
                        n_cur   = r_cur - i_geom.area;
                        n_addr  = r_cur - i_geom.area;
                        n_start = 14'd0;
                    end
                end else begin
                    n_state = S_FOLLOW;
                end
            end
            S_ROWCLR: begin
                n_addr = r_addr + 1'b1;
                n_cnt  = r_cnt + 8'd1;
                if (r_cnt == (i_geom.cols - 8'd1)) begin
                    n_cnt   = 8'd0;
                    n_state = S_FOLLOW;
                end
            end
            S_FOLLOW: begin
                if (in_win || (r_cnt == guard_lim)) begin
                    n_state = S_DONE;
                end else begin
                    n_start = (start_nx == area15) ? 14'd0 : start_nx[13:0];
                    n_cnt   = r_cnt + 8'd1;
                end
            end
            S_READ: begin
                n_data  = i_ram_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid              = 1'b1;
                    n_out_item.cursor_out    = r_cur;
                    n_out_item.display_start = r_start;
                    n_out_item.cell_data     = r_data;
                    n_out_item.applied       = r_applied;
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register write homes the cursor and the window
        if (i_cfg_clr) begin
            n_cur   = 14'd0;
            n_col   = 7'd0;
            n_start = 14'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cur       <= 14'd0;
            r_col       <= 7'd0;
            r_start     <= 14'd0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_col       <= n_col;
            r_start     <= n_start;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_cell     <= n_cell;
        r_newline  <= n_newline;
        r_bs       <= n_bs;
        r_applied  <= n_applied;
        r_data     <= n_data;
        r_out_item <= n_out_item;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

@@ rtl/text_console_cursor_scroll.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text-mode console engine: cursor tracking, newline fill, row clear and
// display start follow over a cell store of two screens.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                Payload
//  ------   ---------  -----------------------  ------------------------------
//  in       input      i_in_valid / o_in_stall  i_in_item  (t_in_item)
//  out      output     o_out_valid / i_out_stall o_out_item (t_out_item)
//  cfg      input      i_cfg_we                 i_cfg_index, i_cfg_wdata
//
//  Reset starts a clearing pass over all 16384 cells (one cell a cycle); items
//  wait on o_in_stall meanwhile, register writes are taken throughout.
//  A character takes 1-2 store writes per cell, a row clear of columns
//  cells at a row start and a display start follow; the single store
//  write port sets this pace. The result register frees the engine: a new
//  item is taken while the previous result still waits under i_out_stall.
//
module text_console_cursor_scroll
    import tccs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // item input
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_item,
    // result output
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_item,
    // register writes
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0]    i_cfg_wdata
);

    // Geometry registers; area kept alongside so no multiply sits in the
    // sequencer paths.
    logic [7:0]  r_cols, n_cols;
    logic [6:0]  r_rows, n_rows;
    logic [13:0] r_area, n_area;

    logic [7:0]  cols_clamped;
    logic [6:0]  rows_clamped;
    logic [6:0]  rows_raw;
    logic [14:0] area_prod;
    t_geom       geom;
    t_ram_req    ram_req;
    logic [15:0] ram_rdata;

    assign rows_raw = i_cfg_wdata[6:0];

    // Out-of-range values are pulled into the legal range
    always_comb begin
        if (i_cfg_wdata == 8'd0) begin
            cols_clamped = 8'd1;
        end else if (i_cfg_wdata > COLS_MAX) begin
            cols_clamped = COLS_MAX;
        end else begin
            cols_clamped = i_cfg_wdata;
        end

        if (rows_raw == 7'd0) begin
            rows_clamped = 7'd1;
        end else if (rows_raw > ROWS_MAX) begin
            rows_clamped = ROWS_MAX;
        end else begin
            rows_clamped = rows_raw;
        end
    end

    always_comb begin
        n_cols    = r_cols;
        n_rows    = r_rows;
        area_prod = {7'b0, r_cols} * {8'b0, r_rows};
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLUMNS: begin
                    n_cols    = cols_clamped;
                    area_prod = {7'b0, cols_clamped} * {8'b0, r_rows};
                end
                CFG_ROWS: begin
                    n_rows    = rows_clamped;
                    area_prod = {7'b0, r_cols} * {8'b0, rows_clamped};
                end
                default: begin
                end
            endcase
        end
        // at most 128 x 64 cells, fits 14 bits
        n_area = area_prod[13:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RST;
            r_rows <= ROWS_RST;
            r_area <= AREA_RST;
        end else begin
            r_cols <= n_cols;
            r_rows <= n_rows;
            r_area <= n_area;
        end
    end

    assign geom.cols = r_cols;
    assign geom.rows = r_rows;
    assign geom.area = r_area;

    tccs_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_cfg_clr   (i_cfg_we),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    tccs_cell_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

endmodule
`default_nettype wire
